// File: hw/rtl/wfmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfmc_pkg
// Shared types, codes and constant tables of the wall-following maneuver
// controller.
// ----------------------------------------------------------------------------
package wfmc_pkg;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_LOST_WALL = 3'd0;
  localparam logic [2:0] REG_TOO_NEAR  = 3'd1;
  localparam logic [2:0] REG_NEAR      = 3'd2;
  localparam logic [2:0] REG_TOO_FAR   = 3'd3;
  localparam logic [2:0] REG_FAR       = 3'd4;
  localparam logic [2:0] REG_LIGHT     = 3'd5;

  // Register reset values.
  localparam int unsigned LostWallRst = 960;
  localparam int unsigned TooNearRst  = 192;
  localparam int unsigned NearRst     = 240;
  localparam int unsigned TooFarRst   = 640;
  localparam int unsigned FarRst      = 480;
  localparam logic [11:0] LightRst    = 12'd500;

  localparam int unsigned LimMinBits  = 14;
  localparam int unsigned LightBits   = 12;
  localparam int unsigned TimeoutBits = 10;

  typedef enum logic [1:0] {
    PH_STOP  = 2'd0,
    PH_NEW   = 2'd1,
    PH_STALE = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    MV_CRUISE        = 4'd0,
    MV_SEARCH_LEFT   = 4'd1,
    MV_SEARCH_FWD    = 4'd2,
    MV_ESCAPE_RIGHT  = 4'd3,
    MV_ESCAPE_FWD    = 4'd4,
    MV_APPROACH_LEFT = 4'd5,
    MV_APPROACH_FWD  = 4'd6,
    MV_APPROACH_RGT  = 4'd7,
    MV_APPROACH_LEFT2 = 4'd8
  } maneuver_e;

  typedef struct packed {
    logic signed [7:0] left_speed;
    logic signed [7:0] right_speed;
    logic              speed_set;
    logic              lights_off;
    logic [3:0]        maneuver;
    logic              maneuver_entered;
    logic              running;
  } wfmc_result_t;

  // Left wheel speed commanded on entry to a maneuver.
  function automatic logic signed [7:0] mv_left(input maneuver_e m);
    logic signed [7:0] v;
    unique case (m)
      MV_CRUISE:         v = 8'sd90;
      MV_SEARCH_LEFT:    v = -8'sd80;
      MV_SEARCH_FWD:     v = 8'sd80;
      MV_ESCAPE_RIGHT:   v = 8'sd80;
      MV_ESCAPE_FWD:     v = 8'sd100;
      MV_APPROACH_LEFT:  v = -8'sd100;
      MV_APPROACH_FWD:   v = 8'sd60;
      MV_APPROACH_RGT:   v = 8'sd100;
      MV_APPROACH_LEFT2: v = -8'sd100;
      default:           v = 8'sd90;
    endcase
    return v;
  endfunction

  // Right wheel speed commanded on entry to a maneuver.
  function automatic logic signed [7:0] mv_right(input maneuver_e m);
    logic signed [7:0] v;
    unique case (m)
      MV_CRUISE:         v = 8'sd90;
      MV_SEARCH_LEFT:    v = 8'sd80;
      MV_SEARCH_FWD:     v = 8'sd80;
      MV_ESCAPE_RIGHT:   v = -8'sd80;
      MV_ESCAPE_FWD:     v = 8'sd100;
      MV_APPROACH_LEFT:  v = 8'sd100;
      MV_APPROACH_FWD:   v = 8'sd60;
      MV_APPROACH_RGT:   v = -8'sd100;
      MV_APPROACH_LEFT2: v = 8'sd100;
      default:           v = 8'sd90;
    endcase
    return v;
  endfunction

  // Duration of a timed maneuver in ms.
  function automatic logic [TimeoutBits-1:0] mv_timeout(input maneuver_e m);
    logic [TimeoutBits-1:0] v;
    unique case (m)
      MV_SEARCH_LEFT:    v = 10'd400;
      MV_SEARCH_FWD:     v = 10'd800;
      MV_ESCAPE_RIGHT:   v = 10'd300;
      MV_ESCAPE_FWD:     v = 10'd300;
      MV_APPROACH_LEFT:  v = 10'd200;
      MV_APPROACH_FWD:   v = 10'd350;
      MV_APPROACH_RGT:   v = 10'd750;
      MV_APPROACH_LEFT2: v = 10'd850;
      default:           v = 10'd0;
    endcase
    return v;
  endfunction

  // Maneuver that follows on timeout.
  function automatic maneuver_e mv_next(input maneuver_e m);
    maneuver_e v;
    unique case (m)
      MV_SEARCH_LEFT:    v = MV_SEARCH_FWD;
      MV_SEARCH_FWD:     v = MV_SEARCH_LEFT;
      MV_ESCAPE_RIGHT:   v = MV_ESCAPE_FWD;
      MV_ESCAPE_FWD:     v = MV_CRUISE;
      MV_APPROACH_LEFT:  v = MV_APPROACH_FWD;
      MV_APPROACH_FWD:   v = MV_APPROACH_RGT;
      MV_APPROACH_RGT:   v = MV_APPROACH_LEFT2;
      MV_APPROACH_LEFT2: v = MV_SEARCH_LEFT;
      default:           v = MV_CRUISE;
    endcase
    return v;
  endfunction

  // Maneuvers that end early once a wall is seen again.
  function automatic logic mv_seeks(input maneuver_e m);
    return (m == MV_SEARCH_LEFT) || (m == MV_SEARCH_FWD) ||
           (m == MV_APPROACH_RGT) || (m == MV_APPROACH_LEFT2);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/wfmc_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfmc_step
// Next-state and result logic for one beat of the maneuver controller.
// ----------------------------------------------------------------------------
module wfmc_step
  import wfmc_pkg::*;
#(
  parameter int unsigned DIST_BITS = 14,
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned LIM_BITS  = 14
) (
  input  logic [1:0]            op_i,
  input  logic [DIST_BITS-1:0]  dist_i,
  input  logic [TIME_BITS-1:0]  now_i,
  input  logic [LightBits-1:0]  light_left_i,
  input  logic [LightBits-1:0]  light_right_i,
  input  logic [LIM_BITS-1:0]   lost_wall_i,
  input  logic [LIM_BITS-1:0]   too_near_i,
  input  logic [LIM_BITS-1:0]   near_i,
  input  logic [LIM_BITS-1:0]   too_far_i,
  input  logic [LIM_BITS-1:0]   far_i,
  input  logic [LightBits-1:0]  light_lim_i,
  input  phase_e                phase_i,
  input  maneuver_e             mnv_i,
  input  logic [DIST_BITS-1:0]  hist_old_i,
  input  logic [DIST_BITS-1:0]  hist_new_i,
  input  logic [1:0]            fill_i,
  input  logic [TIME_BITS-1:0]  start_i,
  output phase_e                phase_o,
  output maneuver_e             mnv_o,
  output logic [DIST_BITS-1:0]  hist_old_o,
  output logic [DIST_BITS-1:0]  hist_new_o,
  output logic [1:0]            fill_o,
  output logic [TIME_BITS-1:0]  start_o,
  output wfmc_result_t          res_o
);

  logic                 full;
  logic [DIST_BITS-1:0] mn;
  logic [LIM_BITS-1:0]  mn_x;
  logic [LIM_BITS-1:0]  dist_x;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] tmo;
  logic                 bright;
  maneuver_e            tgt;
  logic                 do_enter;

  // The window is full once this update brings the third sample in.
  assign full    = (fill_i >= 2'd2);
  assign dist_x  = LIM_BITS'(dist_i);
  assign elapsed = now_i - start_i;
  assign tmo     = TIME_BITS'(mv_timeout(mnv_i));
  assign bright  = (light_left_i >= light_lim_i) || (light_right_i >= light_lim_i);

  always_comb begin
    mn = dist_i;
    if (full) begin
      if (hist_old_i < mn) mn = hist_old_i;
      if (hist_new_i < mn) mn = hist_new_i;
    end
  end

  assign mn_x = LIM_BITS'(mn);

  always_comb begin
    phase_o    = phase_i;
    mnv_o      = mnv_i;
    hist_old_o = hist_old_i;
    hist_new_o = hist_new_i;
    fill_o     = fill_i;
    start_o    = start_i;
    res_o      = '0;
    tgt        = MV_CRUISE;
    do_enter   = 1'b0;

    unique case (op_i)
      OP_UPDATE: begin
        priority if (phase_i == PH_NEW) begin
          mnv_o      = MV_CRUISE;
          hist_old_o = '0;
          hist_new_o = '0;
          fill_o     = 2'd0;
          start_o    = '0;
          phase_o    = PH_STALE;
        end else if (phase_i != PH_STALE) begin
          res_o.speed_set  = 1'b1;
          res_o.lights_off = 1'b1;
        end else if (bright) begin
          phase_o          = PH_STOP;
          res_o.speed_set  = 1'b1;
          res_o.lights_off = 1'b1;
        end else begin
          hist_old_o = hist_new_i;
          hist_new_o = dist_i;
          if (fill_i != 2'd3) fill_o = fill_i + 2'd1;
          if (mnv_i != MV_CRUISE) begin
            priority if (mv_seeks(mnv_i) && (dist_x <= lost_wall_i)) begin
              do_enter = 1'b1;
              tgt      = MV_CRUISE;
            end else if (elapsed >= tmo) begin
              do_enter = 1'b1;
              tgt      = mv_next(mnv_i);
            end else begin
              do_enter = 1'b0;
            end
          end else begin
            priority if (full && (mn_x > lost_wall_i)) begin
              do_enter = 1'b1;
              tgt      = MV_SEARCH_LEFT;
            end else if (full && (mn_x < too_near_i)) begin
              do_enter = 1'b1;
              tgt      = MV_ESCAPE_RIGHT;
            end else if (mn_x < near_i) begin
              res_o.speed_set   = 1'b1;
              res_o.left_speed  = 8'sd100;
              res_o.right_speed = 8'sd30;
            end else if (full && (mn_x > too_far_i)) begin
              do_enter = 1'b1;
              tgt      = MV_APPROACH_LEFT;
            end else if (mn_x > far_i) begin
              res_o.speed_set   = 1'b1;
              res_o.left_speed  = 8'sd40;
              res_o.right_speed = 8'sd100;
            end else begin
              res_o.speed_set   = 1'b1;
              res_o.left_speed  = 8'sd90;
              res_o.right_speed = 8'sd90;
            end
          end
        end
      end
      OP_START: begin
        phase_o = PH_NEW;
      end
      OP_STOP: begin
        phase_o          = PH_STOP;
        res_o.speed_set  = 1'b1;
        res_o.lights_off = 1'b1;
      end
      default: begin
        phase_o = phase_i;
      end
    endcase

    if (do_enter) begin
      mnv_o                  = tgt;
      start_o                = now_i;
      res_o.speed_set        = 1'b1;
      res_o.left_speed       = mv_left(tgt);
      res_o.right_speed      = mv_right(tgt);
      res_o.maneuver_entered = 1'b1;
    end

    res_o.maneuver = mnv_o;
    res_o.running  = (phase_o == PH_NEW) || (phase_o == PH_STALE);
  end

endmodule
`default_nettype wire

// File: hw/rtl/wall_follow_maneuver_controller_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wall_follow_maneuver_controller_core
// Wall-following drive controller: run state, maneuver machine and distance
// window, stepped once per input beat.
// ----------------------------------------------------------------------------
// Usage: each input beat carries an operation (update, start or stop) with a
// distance, a millisecond time stamp and two light readings. Every beat
// produces exactly one result beat with the motor speeds, lamp and maneuver
// flags and the run status. Both channels use valid/ready handshakes.
// A beat accepted into the input register is stepped from there; the step
// logic then writes the controller state and the result register once the
// result register is empty or being drained. Throughput is one beat per
// cycle while the receiver takes every result; the controller state feeds
// back to the step logic directly, so consecutive beats never wait on
// each other. When the receiver stalls, the result register holds and the
// input register can still take one more beat before in_ready_o drops.
// Reset returns every limit register to its default, stops the run, selects
// cruise and clears the distance window and the maneuver start time.
// The limits are to be written through the APB-style port only while no beat
// is pending; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module wall_follow_maneuver_controller_core
  import wfmc_pkg::*;
#(
  parameter int unsigned DIST_BITS = 14,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input channel.
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            op_i,
  input  logic [DIST_BITS-1:0]  distance_i,
  input  logic [TIME_BITS-1:0]  now_ms_i,
  input  logic [11:0]           light_left_i,
  input  logic [11:0]           light_right_i,
  // Result channel.
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [7:0]     left_speed_o,
  output logic signed [7:0]     right_speed_o,
  output logic                  speed_set_o,
  output logic                  lights_off_o,
  output logic [3:0]            maneuver_o,
  output logic                  maneuver_entered_o,
  output logic                  running_o,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // Limit registers are at least as wide as their reset values need.
  localparam int unsigned LimBits = (DIST_BITS > LimMinBits) ? DIST_BITS : LimMinBits;

  // Configuration registers.
  logic [LimBits-1:0]   lost_wall_q, too_near_q, near_q, too_far_q, far_q;
  logic [LightBits-1:0] light_lim_q;
  logic                 cfg_wr;
  logic [2:0]           cfg_idx;
  logic [LimBits-1:0]   cfg_dist;

  // Input register.
  logic                 s1_valid_q;
  logic [1:0]           op_q;
  logic [DIST_BITS-1:0] dist_q;
  logic [TIME_BITS-1:0] now_q;
  logic [LightBits-1:0] ll_q, lr_q;

  // Controller state.
  phase_e               phase_q, phase_d;
  maneuver_e            mnv_q, mnv_d;
  logic [DIST_BITS-1:0] hist_old_q, hist_old_d, hist_new_q, hist_new_d;
  logic [1:0]           fill_q, fill_d;
  logic [TIME_BITS-1:0] start_q, start_d;

  // Result register.
  logic                 out_valid_q;
  wfmc_result_t         res_q, res_d;

  logic                 in_acc;
  logic                 out_free;
  logic                 advance;

  // --------------------------------------------------------------------------
  // Configuration port. Distance limits keep DIST_BITS of the written data.
  // --------------------------------------------------------------------------
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_idx  = paddr[4:2];
  assign cfg_dist = LimBits'(pwdata[DIST_BITS-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lost_wall_q <= LimBits'(LostWallRst);
      too_near_q  <= LimBits'(TooNearRst);
      near_q      <= LimBits'(NearRst);
      too_far_q   <= LimBits'(TooFarRst);
      far_q       <= LimBits'(FarRst);
      light_lim_q <= LightRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LOST_WALL: lost_wall_q <= cfg_dist;
        REG_TOO_NEAR:  too_near_q  <= cfg_dist;
        REG_NEAR:      near_q      <= cfg_dist;
        REG_TOO_FAR:   too_far_q   <= cfg_dist;
        REG_FAR:       far_q       <= cfg_dist;
        REG_LIGHT:     light_lim_q <= pwdata[LightBits-1:0];
        default: begin
          // Writes above the register list are dropped.
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LOST_WALL: prdata = 32'(lost_wall_q);
      REG_TOO_NEAR:  prdata = 32'(too_near_q);
      REG_NEAR:      prdata = 32'(near_q);
      REG_TOO_FAR:   prdata = 32'(too_far_q);
      REG_FAR:       prdata = 32'(far_q);
      REG_LIGHT:     prdata = 32'(light_lim_q);
      default:       prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake. The step runs when the input register holds a beat and the
  // result register is empty or being drained in this cycle.
  // --------------------------------------------------------------------------
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_i;
      dist_q <= distance_i;
      now_q  <= now_ms_i;
      ll_q   <= light_left_i;
      lr_q   <= light_right_i;
    end
  end

  // --------------------------------------------------------------------------
  // Step logic and controller state.
  // --------------------------------------------------------------------------
  wfmc_step #(
    .DIST_BITS (DIST_BITS),
    .TIME_BITS (TIME_BITS),
    .LIM_BITS  (LimBits)
  ) u_step (
    .op_i          (op_q),
    .dist_i        (dist_q),
    .now_i         (now_q),
    .light_left_i  (ll_q),
    .light_right_i (lr_q),
    .lost_wall_i   (lost_wall_q),
    .too_near_i    (too_near_q),
    .near_i        (near_q),
    .too_far_i     (too_far_q),
    .far_i         (far_q),
    .light_lim_i   (light_lim_q),
    .phase_i       (phase_q),
    .mnv_i         (mnv_q),
    .hist_old_i    (hist_old_q),
    .hist_new_i    (hist_new_q),
    .fill_i        (fill_q),
    .start_i       (start_q),
    .phase_o       (phase_d),
    .mnv_o         (mnv_d),
    .hist_old_o    (hist_old_d),
    .hist_new_o    (hist_new_d),
    .fill_o        (fill_d),
    .start_o       (start_d),
    .res_o         (res_d)
  );

  // The window keeps only the two samples before the newest one; the oldest
  // of the three drops out on every shift anyway.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_STOP;
      mnv_q      <= MV_CRUISE;
      hist_old_q <= '0;
      hist_new_q <= '0;
      fill_q     <= 2'd0;
      start_q    <= '0;
    end else if (advance) begin
      phase_q    <= phase_d;
      mnv_q      <= mnv_d;
      hist_old_q <= hist_old_d;
      hist_new_q <= hist_new_d;
      fill_q     <= fill_d;
      start_q    <= start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign left_speed_o       = res_q.left_speed;
  assign right_speed_o      = res_q.right_speed;
  assign speed_set_o        = res_q.speed_set;
  assign lights_off_o       = res_q.lights_off;
  assign maneuver_o         = res_q.maneuver;
  assign maneuver_entered_o = res_q.maneuver_entered;
  assign running_o          = res_q.running;

endmodule
`default_nettype wire

// File: hw/rtl/wfmc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfmc_checker
// Port-level checks of the maneuver controller result channel.
// ----------------------------------------------------------------------------
module wfmc_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic signed [7:0] left_speed_o,
  input  logic signed [7:0] right_speed_o,
  input  logic              speed_set_o,
  input  logic              lights_off_o,
  input  logic [3:0]        maneuver_o,
  input  logic              maneuver_entered_o,
  input  logic              running_o
);

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(left_speed_o) &&
    $stable(right_speed_o) && $stable(speed_set_o) && $stable(maneuver_o) &&
    $stable(running_o))
    else $error("result beat changed while stalled");

  // Speeds are zero whenever no speed was commanded.
  a_no_set_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !speed_set_o |-> left_speed_o == 8'sd0 && right_speed_o == 8'sd0)
    else $error("speed reported without speed_set");

  // Clearing the lamps always comes with a motor stop and never with an entry.
  a_lamps_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && lights_off_o |-> speed_set_o && left_speed_o == 8'sd0 &&
    right_speed_o == 8'sd0 && !maneuver_entered_o && !running_o)
    else $error("lamp clear without a full stop");

  // Entering a maneuver commands speeds while the run is active.
  a_enter_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && maneuver_entered_o |-> speed_set_o && running_o &&
    left_speed_o != 8'sd0)
    else $error("maneuver entered outside an active run");

endmodule

bind wall_follow_maneuver_controller_core wfmc_checker u_wfmc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .left_speed_o       (left_speed_o),
  .right_speed_o      (right_speed_o),
  .speed_set_o        (speed_set_o),
  .lights_off_o       (lights_off_o),
  .maneuver_o         (maneuver_o),
  .maneuver_entered_o (maneuver_entered_o),
  .running_o          (running_o)
);
`default_nettype wire
